>>> hdl/rtrp_pkg.sv
// Shared types, constants and field tables for the radiotap rate and tag parser.
// No dependencies; used by every module in hdl/.
package rtrp_pkg;

  // Frame limit default and field-level widths
  localparam int MAX_FRAME_DEF = 4096;
  localparam int HLEN_W        = 16;
  localparam int CUR_W         = 17;   // cursor arithmetic with carry room
  localparam int NUM_FIELDS    = 22;
  localparam int FIDX_W        = 5;

  // Header layout
  localparam logic [HLEN_W-1:0] HDR_MIN       = 16'd8;
  localparam logic [HLEN_W-1:0] EXT_FIRST_END = 16'd12;
  localparam logic [CUR_W-1:0]  FIRST_CURSOR  = 17'd8;
  localparam logic [CUR_W-1:0]  WORD_BYTES    = 17'd4;
  localparam logic [CUR_W-1:0]  WORD_LAST     = 17'd3;
  localparam logic [CUR_W-1:0]  TAG_MIN_POS   = 17'd15;
  localparam logic [CUR_W-1:0]  TAG_SPAN_LAST = 17'd7;

  // Fields carrying a rate and the byte within each
  localparam logic [FIDX_W-1:0] FIELD_LEGACY = 5'd2;
  localparam logic [FIDX_W-1:0] FIELD_HT     = 5'd19;
  localparam logic [FIDX_W-1:0] FIELD_VHT    = 5'd21;
  localparam logic [CUR_W-1:0]  HT_MCS_BYTE  = 17'd2;
  localparam logic [CUR_W-1:0]  VHT_MCS_BYTE = 17'd4;

  // Configuration reset values
  localparam logic [31:0] TAG_WORD_RST  = 32'h424C_5756;
  localparam logic [7:0]  WIN_FIRST_RST = 8'd20;
  localparam logic [7:0]  WIN_LAST_RST  = 8'd40;

  typedef enum logic [1:0] {
    CFG_TAG_WORD  = 2'd0,
    CFG_WIN_FIRST = 2'd1,
    CFG_WIN_LAST  = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    RATE_LEGACY = 2'd0,
    RATE_VHT    = 2'd1,
    RATE_HT     = 2'd2,
    RATE_NONE   = 2'd3
  } rate_kind_t;

  typedef struct packed {
    logic [31:0] tag_word;
    logic [7:0]  win_first;
    logic [7:0]  win_last;
  } cfg_t;

  typedef struct packed {
    logic       last_byte;
    logic [7:0] frame_byte;
  } byte_item_t;

  typedef struct packed {
    logic        tag_found;
    logic [31:0] frame_seq;
    rate_kind_t  rate_kind;
    logic [7:0]  rate_value;
  } res_t;

  typedef struct packed {
    logic              found;
    logic [FIDX_W-1:0] index;
    logic [HLEN_W-1:0] cursor;
  } seek_t;

  // Size in bytes of each radiotap field, bits 0..21
  function automatic logic [3:0] field_size(input logic [FIDX_W-1:0] idx);
    logic [3:0] s;
    unique case (idx)
      5'd0, 5'd18, 5'd20:                                  s = 4'd8;
      5'd3:                                                s = 4'd4;
      5'd4, 5'd7, 5'd8, 5'd9, 5'd14, 5'd15:                s = 4'd2;
      5'd19:                                               s = 4'd3;
      5'd21:                                               s = 4'd12;
      default:                                             s = 4'd1;
    endcase
    return s;
  endfunction

  // Natural alignment of each field
  function automatic logic [3:0] field_align(input logic [FIDX_W-1:0] idx);
    logic [3:0] a;
    unique case (idx)
      5'd0:                                                a = 4'd8;
      5'd18, 5'd20:                                        a = 4'd4;
      5'd3, 5'd4, 5'd7, 5'd8, 5'd9, 5'd14, 5'd15, 5'd21:   a = 4'd2;
      default:                                             a = 4'd1;
    endcase
    return a;
  endfunction

endpackage

>>> hdl/rtrp_field_seek.sv
// Finds the next present radiotap field at or above a start bit, aligns its
// offset and checks that it fits in the header. Uses rtrp_pkg.
module rtrp_field_seek (
  input  logic [rtrp_pkg::NUM_FIELDS-1:0] present,
  input  logic [rtrp_pkg::FIDX_W-1:0]     from_bit,
  input  logic [rtrp_pkg::CUR_W-1:0]      cur,
  input  logic [rtrp_pkg::HLEN_W-1:0]     hlen,
  output rtrp_pkg::seek_t                 seek
);

  logic                          any_set;
  logic [rtrp_pkg::FIDX_W-1:0]   first_idx;
  logic [rtrp_pkg::CUR_W-1:0]    amask;
  logic [rtrp_pkg::CUR_W-1:0]    aligned;
  logic [rtrp_pkg::CUR_W:0]      field_end;

  // Lowest present bit at or above from_bit
  always_comb begin
    any_set   = 1'b0;
    first_idx = '0;
    for (int i = rtrp_pkg::NUM_FIELDS - 1; i >= 0; i--) begin
      if (present[i] && (rtrp_pkg::FIDX_W'(i) >= from_bit)) begin
        any_set   = 1'b1;
        first_idx = rtrp_pkg::FIDX_W'(i);
      end
    end
  end

  // Round the cursor up to the field's alignment, then check the fit
  always_comb begin
    amask     = rtrp_pkg::CUR_W'(rtrp_pkg::field_align(first_idx)) - 1'b1;
    aligned   = (cur + amask) & ~amask;
    field_end = {1'b0, aligned} + (rtrp_pkg::CUR_W + 1)'(rtrp_pkg::field_size(first_idx));
    seek.found  = any_set && (field_end <= (rtrp_pkg::CUR_W + 1)'(hlen));
    seek.index  = first_idx;
    seek.cursor = aligned[rtrp_pkg::HLEN_W-1:0];
  end

endmodule

>>> hdl/rtrp_frame_core.sv
// Per-frame parse state: header length, present bitmap, field walk, rate
// captures and tag search. One byte per advance. Uses rtrp_pkg, rtrp_field_seek.
module rtrp_frame_core #(
  parameter int MAX_FRAME = rtrp_pkg::MAX_FRAME_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 advance,
  input  rtrp_pkg::byte_item_t item,
  input  rtrp_pkg::cfg_t       cfg,
  output rtrp_pkg::res_t       res
);

  localparam int POS_W = $clog2(MAX_FRAME + 1);
  localparam int CW    = rtrp_pkg::CUR_W;

  // Frame state
  logic [POS_W-1:0]                pos_r,      pos_nxt;
  logic [rtrp_pkg::HLEN_W-1:0]     hlen_r,     hlen_nxt;
  logic [rtrp_pkg::NUM_FIELDS-1:0] present_r,  present_nxt;
  logic                            ext_r,      ext_nxt;
  logic [rtrp_pkg::HLEN_W-1:0]     cursor_r,   cursor_nxt;
  logic [rtrp_pkg::FIDX_W-1:0]     fidx_r,     fidx_nxt;
  logic                            stopped_r,  stopped_nxt;
  logic                            walk_r,     walk_nxt;
  logic                            leg_v_r,    leg_v_nxt;
  logic [7:0]                      leg_r,      leg_nxt;
  logic                            ht_v_r,     ht_v_nxt;
  logic [4:0]                      ht_r,       ht_nxt;
  logic                            vht_v_r,    vht_v_nxt;
  logic [3:0]                      vht_r,      vht_nxt;
  logic [63:0]                     recent_r,   recent_nxt;
  logic                            hit_r,      hit_nxt;
  logic [31:0]                     seq_r,      seq_nxt;

  // Seek unit request
  logic                            seek_req;
  logic [rtrp_pkg::FIDX_W-1:0]     seek_from;
  logic [CW-1:0]                   seek_cur;
  rtrp_pkg::seek_t                 seek;

  rtrp_field_seek u_seek (
    .present  (present_nxt),
    .from_bit (seek_from),
    .cur      (seek_cur),
    .hlen     (hlen_r),
    .seek     (seek)
  );

  // Byte update
  always_comb begin
    logic [7:0]    b;
    logic [CW-1:0] p;
    logic [CW-1:0] cur;
    logic [CW-1:0] cur4;
    logic [CW-1:0] hl;
    logic [CW-1:0] off;
    logic          take;

    b    = item.frame_byte;
    p    = CW'(pos_r);
    cur  = CW'(cursor_r);
    cur4 = cur + rtrp_pkg::WORD_BYTES;
    hl   = CW'(hlen_r);
    off  = p - rtrp_pkg::TAG_SPAN_LAST - hl;
    take = pos_r < POS_W'(MAX_FRAME);

    pos_nxt     = pos_r;
    hlen_nxt    = hlen_r;
    present_nxt = present_r;
    ext_nxt     = ext_r;
    cursor_nxt  = cursor_r;
    fidx_nxt    = fidx_r;
    stopped_nxt = stopped_r;
    walk_nxt    = walk_r;
    leg_v_nxt   = leg_v_r;
    leg_nxt     = leg_r;
    ht_v_nxt    = ht_v_r;
    ht_nxt      = ht_r;
    vht_v_nxt   = vht_v_r;
    vht_nxt     = vht_r;
    recent_nxt  = recent_r;
    hit_nxt     = hit_r;
    seq_nxt     = seq_r;
    seek_req    = 1'b0;
    seek_from   = '0;
    seek_cur    = rtrp_pkg::FIRST_CURSOR;

    if (take) begin
      recent_nxt = {b, recent_r[63:8]};
      pos_nxt    = pos_r + 1'b1;

      // Header words, extension chain, field walk
      priority if (p == CW'(2)) begin
        hlen_nxt = {8'h00, b};
      end else if (p == CW'(3)) begin
        hlen_nxt = {b, hlen_r[7:0]};
      end else if (p == CW'(4)) begin
        present_nxt = {14'h0, b};
      end else if (p == CW'(5)) begin
        present_nxt[15:8] = b;
      end else if (p == CW'(6)) begin
        present_nxt[21:16] = b[5:0];
      end else if (p == CW'(7)) begin
        ext_nxt    = b[7];
        cursor_nxt = rtrp_pkg::FIRST_CURSOR[rtrp_pkg::HLEN_W-1:0];
        if (b[7]) begin
          if (rtrp_pkg::EXT_FIRST_END > hlen_r) stopped_nxt = 1'b1;
        end else begin
          seek_req = 1'b1;
        end
      end else if (ext_r && !stopped_r) begin
        if (p == cur + rtrp_pkg::WORD_LAST) begin
          ext_nxt    = b[7];
          cursor_nxt = cur4[rtrp_pkg::HLEN_W-1:0];
          if (b[7]) begin
            if ((cur4 + rtrp_pkg::WORD_BYTES) > hl) stopped_nxt = 1'b1;
          end else begin
            seek_req = 1'b1;
            seek_cur = cur4;
          end
        end
      end else if (walk_r) begin
        if (fidx_r == rtrp_pkg::FIELD_LEGACY && p == cur) begin
          leg_v_nxt = 1'b1;
          leg_nxt   = b;
        end
        if (fidx_r == rtrp_pkg::FIELD_HT && p == cur + rtrp_pkg::HT_MCS_BYTE) begin
          ht_v_nxt = 1'b1;
          ht_nxt   = b[4:0];
        end
        if (fidx_r == rtrp_pkg::FIELD_VHT && p == cur + rtrp_pkg::VHT_MCS_BYTE) begin
          vht_v_nxt = 1'b1;
          vht_nxt   = b[7:4];
        end
        // last byte of the current field: move on
        if (p == cur + CW'(rtrp_pkg::field_size(fidx_r)) - 1'b1) begin
          seek_req  = 1'b1;
          seek_from = fidx_r + 1'b1;
          seek_cur  = p + 1'b1;
        end
      end else begin
        // leading bytes, stopped walk or payload: nothing to parse here
      end

      if (seek_req) begin
        if (seek.found) begin
          fidx_nxt   = seek.index;
          cursor_nxt = seek.cursor;
          walk_nxt   = 1'b1;
        end else begin
          walk_nxt    = 1'b0;
          stopped_nxt = 1'b1;
        end
      end

      // Tag and sequence in the payload window
      if (!hit_r && p >= rtrp_pkg::TAG_MIN_POS && hlen_r >= rtrp_pkg::HDR_MIN &&
          p >= hl + rtrp_pkg::TAG_SPAN_LAST) begin
        if (off >= CW'(cfg.win_first) && off <= CW'(cfg.win_last) &&
            recent_nxt[31:0] == cfg.tag_word) begin
          hit_nxt = 1'b1;
          seq_nxt = recent_nxt[63:32];
        end
      end
    end
  end

  // Result as seen after this byte
  always_comb begin
    logic ok;
    ok = (pos_nxt >= POS_W'(8)) && (hlen_nxt >= rtrp_pkg::HDR_MIN) &&
         (CW'(hlen_nxt) <= CW'(pos_nxt));
    res.tag_found = hit_nxt;
    res.frame_seq = hit_nxt ? seq_nxt : 32'h0;
    priority if (ok && leg_v_nxt) begin
      res.rate_kind  = rtrp_pkg::RATE_LEGACY;
      res.rate_value = leg_nxt;
    end else if (ok && vht_v_nxt) begin
      res.rate_kind  = rtrp_pkg::RATE_VHT;
      res.rate_value = {4'h0, vht_nxt};
    end else if (ok && ht_v_nxt) begin
      res.rate_kind  = rtrp_pkg::RATE_HT;
      res.rate_value = {3'h0, ht_nxt};
    end else begin
      res.rate_kind  = rtrp_pkg::RATE_NONE;
      res.rate_value = 8'h00;
    end
  end

  // Control state: cleared at reset and at the end of each frame
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r     <= '0;
      hlen_r    <= '0;
      present_r <= '0;
      ext_r     <= 1'b0;
      cursor_r  <= '0;
      fidx_r    <= '0;
      stopped_r <= 1'b0;
      walk_r    <= 1'b0;
      leg_v_r   <= 1'b0;
      ht_v_r    <= 1'b0;
      vht_v_r   <= 1'b0;
      hit_r     <= 1'b0;
    end else if (advance) begin
      if (item.last_byte) begin
        pos_r     <= '0;
        hlen_r    <= '0;
        present_r <= '0;
        ext_r     <= 1'b0;
        cursor_r  <= '0;
        fidx_r    <= '0;
        stopped_r <= 1'b0;
        walk_r    <= 1'b0;
        leg_v_r   <= 1'b0;
        ht_v_r    <= 1'b0;
        vht_v_r   <= 1'b0;
        hit_r     <= 1'b0;
      end else begin
        pos_r     <= pos_nxt;
        hlen_r    <= hlen_nxt;
        present_r <= present_nxt;
        ext_r     <= ext_nxt;
        cursor_r  <= cursor_nxt;
        fidx_r    <= fidx_nxt;
        stopped_r <= stopped_nxt;
        walk_r    <= walk_nxt;
        leg_v_r   <= leg_v_nxt;
        ht_v_r    <= ht_v_nxt;
        vht_v_r   <= vht_v_nxt;
        hit_r     <= hit_nxt;
      end
    end
  end

  // Payload state, qualified by the valid bits above
  always_ff @(posedge clk) begin
    if (advance) begin
      leg_r    <= leg_nxt;
      ht_r     <= ht_nxt;
      vht_r    <= vht_nxt;
      recent_r <= recent_nxt;
      seq_r    <= seq_nxt;
    end
  end

endmodule

>>> hdl/radiotap_rate_and_tag_parser.sv
// Top level of the radiotap rate and tag parser: stream ports, configuration
// registers, input and result registers. Uses rtrp_pkg, rtrp_frame_core.

// Takes a captured frame one byte per transaction (tlast on the final byte) and
// returns one result transaction per frame: tag flag and sequence number found
// in the payload window, and the best rate seen (legacy, then VHT, then HT).
// A new byte is accepted every cycle unless a last byte waits for the result
// slot; each byte is held in the input register and parsed there, with the
// present-bit search, alignment and fit check of the field walk done in the
// same cycle, and a parsed last byte loads the result register. A result not
// yet taken stalls input only when the next frame's last byte is ready to be
// parsed. Bytes at or past MAX_FRAME are dropped but tlast still closes the
// frame. There is no start-up clearing pass. Configuration writes are always
// accepted and must be made only while no frame is in flight.
module radiotap_rate_and_tag_parser #(
  parameter int MAX_FRAME = rtrp_pkg::MAX_FRAME_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Frame bytes
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] frame_byte
  input  logic        in_tlast,    // last_byte
  // Results
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,   // [31:0] frame_seq, [39:32] rate_value
  output logic [2:0]  out_tuser,   // [0] tag_found, [2:1] rate_kind
  // Configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  rtrp_pkg::cfg_t       cfg_r;
  logic                 s1_valid_r;
  rtrp_pkg::byte_item_t s1_item_r;
  logic                 s1_take;
  rtrp_pkg::res_t       res;
  logic                 out_valid_r;
  rtrp_pkg::res_t       out_res_r;

  // Configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.tag_word  <= rtrp_pkg::TAG_WORD_RST;
      cfg_r.win_first <= rtrp_pkg::WIN_FIRST_RST;
      cfg_r.win_last  <= rtrp_pkg::WIN_LAST_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (rtrp_pkg::cfg_reg_t'(cfg_index))
        rtrp_pkg::CFG_TAG_WORD:  cfg_r.tag_word  <= cfg_data;
        rtrp_pkg::CFG_WIN_FIRST: cfg_r.win_first <= cfg_data[7:0];
        rtrp_pkg::CFG_WIN_LAST:  cfg_r.win_last  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Input register; a last byte waits only for a free result slot
  assign s1_take   = s1_valid_r && (!s1_item_r.last_byte || !out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_item_r.frame_byte <= in_tdata;
      s1_item_r.last_byte  <= in_tlast;
    end
  end

  rtrp_frame_core #(
    .MAX_FRAME (MAX_FRAME)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (s1_take),
    .item    (s1_item_r),
    .cfg     (cfg_r),
    .res     (res)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_take && s1_item_r.last_byte) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take && s1_item_r.last_byte) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.rate_value, out_res_r.frame_seq};
  assign out_tuser  = {out_res_r.rate_kind, out_res_r.tag_found};

  // Checks
  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_take && s1_item_r.last_byte) |=> out_tvalid)
    else $error("parsed last byte did not load a result");

  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(s1_take && s1_item_r.last_byte))
    else $error("result raised without a last byte");

  a_no_tag_no_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser[0]) |-> (out_tdata[31:0] == 32'h0))
    else $error("sequence reported without a tag");

  a_unknown_rate_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[2:1] == rtrp_pkg::RATE_NONE) |-> (out_tdata[39:32] == 8'h0))
    else $error("unknown rate with nonzero value");

endmodule
